// ===== rtl/pfma_pkg.sv =====
package pfma_pkg;

    // fixed field widths of the channels
    localparam int FIELD_BITS    = 64;
    localparam int OP_BITS       = 3;
    localparam int STATUS_BITS   = 2;
    localparam int WORD_BITS_DEF = 64;

    // modulus after reset
    localparam logic [FIELD_BITS-1:0] RESET_MODULUS = 64'd7514777789;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_INV = 3'd5
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK           = 2'd0,
        ST_NOT_INV      = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INV_CHK,
        S_INV_DIV,
        S_INV_MUL,
        S_MUL,
        S_DONE
    } t_state;

endpackage

// ===== rtl/pfma_if.sv =====
// operation channel
interface pfma_in_if import pfma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    op;
    logic [FIELD_BITS-1:0] operand_a;
    logic [FIELD_BITS-1:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

// result channel
interface pfma_out_if import pfma_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_BITS-1:0]  result;
    logic [STATUS_BITS-1:0] status;

    modport source (output valid, output result, output status, input ready);
    modport sink   (input valid, input result, input status, output ready);
endinterface

// modulus write channel
interface pfma_cfg_if import pfma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/prime_field_modular_alu.sv =====
// Add, subtract, negate: operands registered on transfer, result register written in S_EXEC,
// copied to the output register in S_DONE; multiply waits in S_MUL for the bit-serial multiplier.
// Invert: each Euclid iteration is a serial divide, then a serial multiply (S_INV_CHK, S_INV_DIV,
// S_INV_MUL), up to about 1.44 * WORD_BITS iterations; divide adds one multiply.
// Throughput: one item at a time; the next is taken once the result is in the output register.
// Reset (synchronous, active low): modulus back to 7514777789, output register empty.
module prime_field_modular_alu import pfma_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfma_cfg_if.sink     i_cfg,
    pfma_in_if.sink      i_in,
    pfma_out_if.source   o_out
);
    localparam int W = WORD_BITS;

    t_state       r_state, n_state;
    logic [OP_BITS-1:0] r_op, n_op;
    logic [W-1:0] r_a, n_a;
    logic [W-1:0] r_b, n_b;
    logic [W-1:0] r_m, n_m;
    // Euclid registers
    logic [W-1:0] r_r, n_r;
    logic [W-1:0] r_nr, n_nr;
    logic [W-1:0] r_t, n_t;
    logic [W-1:0] r_nt, n_nt;
    // result in flight and output register
    logic [W-1:0] r_res, n_res;
    t_status      r_st, n_st;
    logic [W-1:0] r_out_res, n_out_res;
    t_status      r_out_st, n_out_st;
    logic         r_out_vld, n_out_vld;

    logic         mul_start, mul_done;
    logic [W-1:0] mul_x, mul_y, mul_p;
    logic         div_start, div_done;
    logic [W-1:0] div_q, div_rem;

    logic [W:0]   add_s;
    logic [W-1:0] add_res, sub_res, neg_res, qm, t_sub, nt_init;
    logic         range_bad;

    // simple operations
    assign add_s   = {1'b0, r_a} + {1'b0, r_b};
    assign add_res = (add_s >= {1'b0, r_m}) ? W'(add_s - {1'b0, r_m}) : add_s[W-1:0];
    assign sub_res = (r_a < r_b) ? r_a + (r_m - r_b) : r_a - r_b;
    assign neg_res = (r_a == '0) ? '0 : r_m - r_a;
    // quotient is at most m; m itself reduces to zero
    assign qm      = (div_q == r_m) ? '0 : div_q;
    assign t_sub   = (r_t < mul_p) ? r_t + (r_m - mul_p) : r_t - mul_p;
    assign nt_init = (r_m == W'(1)) ? '0 : W'(1);

    always_comb begin
        range_bad = (r_a >= r_m);
        if (r_op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
            range_bad = range_bad || (r_b >= r_m);
        end else if (!(r_op inside {OP_NEG, OP_INV})) begin
            range_bad = 1'b1;
        end
    end

    // handshakes
    assign i_cfg.ready  = 1'b1;
    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_vld;
    assign o_out.result = FIELD_BITS'(r_out_res);
    assign o_out.status = r_out_st;

    // sequencer and datapath next values
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_a       = r_a;
        n_b       = r_b;
        n_m       = r_m;
        n_r       = r_r;
        n_nr      = r_nr;
        n_t       = r_t;
        n_nt      = r_nt;
        n_res     = r_res;
        n_st      = r_st;
        n_out_res = r_out_res;
        n_out_st  = r_out_st;
        n_out_vld = r_out_vld;
        mul_start = 1'b0;
        mul_x     = '0;
        mul_y     = '0;
        div_start = 1'b0;

        if (i_cfg.valid) begin
            n_m = i_cfg.data[W-1:0];
        end
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.op;
                    n_a     = i_in.operand_a[W-1:0];
                    n_b     = i_in.operand_b[W-1:0];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_st    = ST_OK;
                n_state = S_DONE;
                n_r     = r_m;
                n_t     = '0;
                n_nt    = nt_init;
                n_nr    = (r_op == OP_DIV) ? r_b : r_a;
                if (range_bad) begin
                    n_st = ST_OUT_OF_RANGE;
                end else begin
                    case (r_op)
                        OP_ADD: n_res = add_res;
                        OP_SUB: n_res = sub_res;
                        OP_NEG: n_res = neg_res;
                        OP_MUL: begin
                            mul_start = 1'b1;
                            mul_x     = r_a;
                            mul_y     = r_b;
                            n_state   = S_MUL;
                        end
                        default: n_state = S_INV_CHK;
                    endcase
                end
            end
            S_INV_CHK: begin
                if (r_nr == '0) begin
                    if (r_r > W'(1)) begin
                        n_res   = '0;
                        n_st    = ST_NOT_INV;
                        n_state = S_DONE;
                    end else if (r_op == OP_DIV) begin
                        mul_start = 1'b1;
                        mul_x     = r_a;
                        mul_y     = r_t;
                        n_state   = S_MUL;
                    end else begin
                        n_res   = r_t;
                        n_state = S_DONE;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = S_INV_DIV;
                end
            end
            S_INV_DIV: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_x     = qm;
                    mul_y     = r_nt;
                    n_state   = S_INV_MUL;
                end
            end
            S_INV_MUL: begin
                // t, nt <- nt, t - q*nt ; r, nr <- nr, r mod nr
                if (mul_done) begin
                    n_t     = r_nt;
                    n_nt    = t_sub;
                    n_r     = r_nr;
                    n_nr    = div_rem;
                    n_state = S_INV_CHK;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_res   = mul_p;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_res = r_res;
                    n_out_st  = r_st;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m       <= RESET_MODULUS[W-1:0];
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m       <= n_m;
            r_out_vld <= n_out_vld;
        end
        r_op      <= n_op;
        r_a       <= n_a;
        r_b       <= n_b;
        r_r       <= n_r;
        r_nr      <= n_nr;
        r_t       <= n_t;
        r_nt      <= n_nt;
        r_res     <= n_res;
        r_st      <= n_st;
        r_out_res <= n_out_res;
        r_out_st  <= n_out_st;
    end

    pfma_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .i_m     (r_m),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    pfma_divu #(.WORD_BITS(WORD_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_r),
        .i_den   (r_nr),
        .o_done  (div_done),
        .o_quo   (div_q),
        .o_rem   (div_rem)
    );

endmodule

// ===== rtl/pfma_mulmod.sv =====
// Bit-serial modular multiplier: one bit of y per cycle, MSB first.
// Needs x, y < m. Product is valid when o_done pulses and held until next start.
module pfma_mulmod import pfma_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_x,
    input  logic [WORD_BITS-1:0] i_y,
    input  logic [WORD_BITS-1:0] i_m,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_prod
);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_x, n_x;
    logic [W-1:0]  r_y, n_y;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [W:0]    dbl;
    logic [W-1:0]  dbl_red;
    logic [W:0]    sum;
    logic [W-1:0]  sum_red;

    // double, reduce, conditionally add x, reduce
    assign dbl     = {r_acc, 1'b0};
    assign dbl_red = (dbl >= {1'b0, i_m}) ? W'(dbl - {1'b0, i_m}) : dbl[W-1:0];
    assign sum     = {1'b0, dbl_red} + {1'b0, r_x};
    assign sum_red = (sum >= {1'b0, i_m}) ? W'(sum - {1'b0, i_m}) : sum[W-1:0];

    always_comb begin
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_x    = i_x;
            n_y    = i_y;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = r_y[W-1] ? sum_red : dbl_red;
            n_y   = {r_y[W-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/pfma_divu.sv =====
// Restoring divider, one quotient bit per cycle. Needs a non-zero divisor.
// Quotient and remainder held after o_done until the next start.
module pfma_divu import pfma_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_num,
    input  logic [WORD_BITS-1:0] i_den,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_quo,
    output logic [WORD_BITS-1:0] o_rem
);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_den, n_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [W:0]    trial;
    logic          fits;

    // numerator shifts through the quotient register, MSB first
    assign trial = {r_rem, r_quo[W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? W'(trial - {1'b0, r_den}) : trial[W-1:0];
            n_quo = {r_quo[W-2:0], fits};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== test/prime_field_alu_checker.sv =====
// Watches the modulus, operation and result channels, predicts each result
// and compares it with what the block returns.
module prime_field_alu_checker import pfma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pfma_cfg_if  i_cfg,
    pfma_in_if   i_in,
    pfma_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FIELD_BITS-1:0] result;
        t_status               status;
    } t_outcome;

    logic [FIELD_BITS-1:0] field_modulus;
    t_outcome              awaited_results[$];

    // compare-and-correct addition, x, y < m
    function automatic logic [63:0] field_add(input logic [63:0] x, y, m);
        logic [63:0] gap;
        gap = m - y;
        return (x >= gap) ? x - gap : x + y;
    endfunction

    function automatic logic [63:0] field_sub(input logic [63:0] x, y, m);
        return (x < y) ? x + (m - y) : x - y;
    endfunction

    // double-and-add over the bits of y, most significant first
    function automatic logic [63:0] field_mul(input logic [63:0] x, y, m);
        logic [63:0] acc;
        acc = '0;
        for (int i = 63; i >= 0; i--) begin
            acc = field_add(acc, acc, m);
            if (y[i])
                acc = field_add(acc, x, m);
        end
        return acc;
    endfunction

    // extended Euclid; returns 0 when gcd(x, m) exceeds one
    function automatic logic field_inverse(input logic [63:0] x, m,
                                           output logic [63:0] inv);
        logic [63:0] r, nr, t, nt, q, tmp;
        r  = m;
        nr = x;
        t  = '0;
        nt = (m == 64'd1) ? 64'd0 : 64'd1;
        while (nr != 0) begin
            q   = r / nr;
            tmp = field_sub(t, field_mul(q % m, nt, m), m);
            t   = nt;
            nt  = tmp;
            tmp = r - q * nr;
            r   = nr;
            nr  = tmp;
        end
        inv = (r > 64'd1) ? 64'd0 : t;
        return (r <= 64'd1);
    endfunction

    function automatic t_outcome field_outcome(input logic [OP_BITS-1:0] op,
                                               input logic [63:0] a, b, m);
        t_outcome    o;
        logic        needs_b;
        logic [63:0] ib;
        o.result = '0;
        o.status = ST_OK;
        needs_b  = (op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_DIV);
        if (op > OP_INV || a >= m || (needs_b && b >= m)) begin
            o.status = ST_OUT_OF_RANGE;
        end else begin
            case (t_op'(op))
                OP_ADD: o.result = field_add(a, b, m);
                OP_SUB: o.result = field_sub(a, b, m);
                OP_NEG: o.result = (a == 0) ? 64'd0 : m - a;
                OP_MUL: o.result = field_mul(a, b, m);
                OP_DIV: begin
                    if (field_inverse(b, m, ib))
                        o.result = field_mul(a, ib, m);
                    else
                        o.status = ST_NOT_INV;
                end
                default: begin
                    if (!field_inverse(a, m, o.result))
                        o.status = ST_NOT_INV;
                end
            endcase
        end
        return o;
    endfunction

    assign o_pending = awaited_results.size();

    // track the modulus, queue predictions, check results
    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (!i_rst_n) begin
            field_modulus = RESET_MODULUS;
            awaited_results.delete();
            o_fail_count <= o_fail_count;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                field_modulus = i_cfg.data;
            if (i_out.valid && i_out.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing outstanding: result %0d status %0d",
                           i_out.result, i_out.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_o = awaited_results.pop_front();
                    if (exp_o.result !== i_out.result || exp_o.status !== i_out.status)
                        o_fail_count <= o_fail_count + 1;
                    if (exp_o.result !== i_out.result)
                        $error("result: expected %0d actual %0d", exp_o.result, i_out.result);
                    if (exp_o.status !== i_out.status)
                        $error("status: expected %0d actual %0d", exp_o.status, i_out.status);
                end
            end
            if (i_in.valid && i_in.ready)
                awaited_results = {awaited_results,
                                   field_outcome(i_in.op, i_in.operand_a,
                                                 i_in.operand_b, field_modulus)};
        end
    end

    initial o_fail_count = 0;

endmodule

// ===== test/prime_field_modular_alu_test.sv =====
// Stimulus and verdict for the prime field ALU.
module prime_field_modular_alu_test import pfma_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned CYCLE_LIMIT = 30_000_000;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    longint      cycle_count;
    bit          steady;   // no gaps on the operation side in this stretch

    pfma_cfg_if cfg_ch();
    pfma_in_if  op_ch();
    pfma_out_if res_ch();

    prime_field_modular_alu uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (op_ch),
        .o_out  (res_ch)
    );

    prime_field_alu_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_ch),
        .i_in        (op_ch),
        .i_out       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure, held for random stretches
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            hold = 0;
        end else if (hold > 0) begin
            hold--;
        end else if ($urandom_range(0, 3) == 0) begin
            res_ch.ready <= ~res_ch.ready;
            hold = res_ch.ready ? idle_len() : $urandom_range(0, 40);
        end
    end

    task automatic write_modulus(input logic [63:0] m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_op(input logic [OP_BITS-1:0] op, input logic [63:0] a, b);
        int gap;
        op_ch.valid     <= 1'b1;
        op_ch.op        <= op;
        op_ch.operand_a <= a;
        op_ch.operand_b <= b;
        do @(posedge i_clk); while (!op_ch.ready);
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        op_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // element mostly in the field, with edges and full-width values
    function automatic logic [63:0] pick_elem(input logic [63:0] m);
        int          r;
        logic [63:0] w;
        r = $urandom_range(0, 99);
        w = {$urandom, $urandom};
        if (r < 8) return 64'd0;
        if (r < 16 && m != 0) return m - 1;
        if (r < 24 || m == 0) return w;
        return w % m;
    endfunction

    task automatic random_phase(input logic [63:0] m, input int count);
        logic [OP_BITS-1:0] op;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0)
                steady = ~steady;
            op = ($urandom_range(0, 19) == 0) ? OP_BITS'($urandom_range(6, 7))
                                               : OP_BITS'($urandom_range(OP_ADD, OP_INV));
            send_op(op, pick_elem(m), pick_elem(m));
        end
        settle();
    endtask

    localparam logic [63:0] MAXW   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] M0     = RESET_MODULUS;

    initial begin
        cycle_count     = 0;
        steady          = 1'b0;
        i_rst_n         = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        op_ch.valid     = 1'b0;
        op_ch.op        = OP_ADD;
        op_ch.operand_a = '0;
        op_ch.operand_b = '0;
        res_ch.ready    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset modulus
        send_op(OP_ADD, M0 - 1, M0 - 1);
        send_op(OP_ADD, 64'd0, 64'd0);
        send_op(OP_SUB, 64'd0, M0 - 1);
        send_op(OP_SUB, M0 - 1, 64'd0);
        send_op(OP_NEG, 64'd0, MAXW);
        send_op(OP_NEG, M0 - 1, 64'd5);
        send_op(OP_MUL, M0 - 1, M0 - 1);
        send_op(OP_MUL, 64'd12345, 64'd0);
        send_op(OP_DIV, 64'd77, 64'd0);
        send_op(OP_DIV, M0 - 1, 64'd3);
        send_op(OP_INV, 64'd0, 64'd0);
        send_op(OP_INV, 64'd1, MAXW);
        send_op(OP_INV, M0 - 1, 64'd0);
        send_op(OP_ADD, M0, 64'd1);
        send_op(OP_ADD, 64'd1, M0);
        send_op(OP_MUL, MAXW, 64'd2);
        send_op(OP_DIV, 64'd2, MAXW);
        send_op(OP_NEG, MAXW, 64'd0);
        send_op(OP_INV, M0, 64'd0);
        send_op(3'd6, 64'd1, 64'd1);
        send_op(3'd7, 64'd0, 64'd0);
        settle();
        random_phase(M0, 130);

        // extremes and small fields first, a few wide ones last
        write_modulus(64'd0);                   random_phase(64'd0, 30);
        write_modulus(64'd1);                   random_phase(64'd1, 30);
        write_modulus(64'd2);                   random_phase(64'd2, 40);
        write_modulus(64'd12);                  random_phase(64'd12, 60);
        write_modulus(64'd13);                  random_phase(64'd13, 80);
        write_modulus(64'd65537);               random_phase(64'd65537, 100);
        write_modulus(64'd2305843009213693951); random_phase(64'd2305843009213693951, 60);
        write_modulus(64'd18446744073709551557);
        random_phase(64'd18446744073709551557, 60);
        write_modulus(MAXW);                    random_phase(MAXW, 40);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
